### sv/bankers_safety_check_core_macros.svh
// Assertion macros shared by the core's modules.
// Each macro expects the module to have aclk and aresetn in scope.
`ifndef BANKERS_SAFETY_CHECK_CORE_MACROS_SVH
`define BANKERS_SAFETY_CHECK_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BSC_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BSC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/bsc_pkg.sv
package bsc_pkg;

    localparam int NUM_PROCS   = 8;
    localparam int NUM_RES     = 4;
    localparam int COUNT_WIDTH = 8;

    localparam int FUNC_W     = 3;
    localparam int PROCF_W    = 3;
    localparam int RESF_W     = 2;
    localparam int VALUE_W    = 8;
    localparam int REQ_W      = 8;
    localparam int NUM_REQ_IN = 4;
    localparam int STATUS_W   = 2;
    localparam int SEQ_W      = 3;

    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 8;

    localparam int PROC_W = $clog2(NUM_PROCS);
    localparam int RES_W  = (NUM_RES > 1) ? $clog2(NUM_RES) : 1;
    localparam int WORK_W = COUNT_WIDTH + $clog2(NUM_PROCS + 1);
    localparam int NEED_W = COUNT_WIDTH + 1;
    localparam int MAX_W  = (REQ_W > COUNT_WIDTH) ? REQ_W : COUNT_WIDTH;
    localparam int CMP_W  = MAX_W + 2;

    localparam logic [FUNC_W-1:0] FUNC_WR_MAX  = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_WR_HELD = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_WR_FREE = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_SAFETY  = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_REQUEST = 3'd4;

    localparam logic [STATUS_W-1:0] STS_SAFE    = 2'd0;
    localparam logic [STATUS_W-1:0] STS_UNSAFE  = 2'd1;
    localparam logic [STATUS_W-1:0] STS_EXCEED  = 2'd2;
    localparam logic [STATUS_W-1:0] STS_NOTFREE = 2'd3;

    typedef logic [COUNT_WIDTH-1:0] count_t;
    typedef logic [WORK_W-1:0]      work_t;
    typedef logic [PROC_W-1:0]      pidx_t;
    typedef logic [RES_W-1:0]       ridx_t;
    typedef logic [REQ_W-1:0]       req_t;
    typedef logic [STATUS_W-1:0]    status_t;

    localparam pidx_t LAST_P = pidx_t'(NUM_PROCS - 1);

    typedef struct packed {
        logic  wr_max;
        logic  wr_held;
        logic  wr_free;
        logic  load;
        logic  safe_start;
        logic  trial_start;
        logic  use_scan;
        logic  finish;
        pidx_t p_idx;
        pidx_t done_idx;
        pidx_t k_idx;
    } cmd_t;

    typedef struct packed {
        logic  proc_ok;
        logic  req_exceeds;
        logic  req_notfree;
        logic  fits;
        pidx_t seq;
    } sts_t;

endpackage

### sv/bsc_datapath.sv
`include "bankers_safety_check_core_macros.svh"

module bsc_datapath (
    input  logic                                         aclk,
    input  logic                                         aresetn,
    input  logic [bsc_pkg::PROCF_W-1:0]                  in_proc,
    input  logic [bsc_pkg::RESF_W-1:0]                   in_res,
    input  logic [bsc_pkg::VALUE_W-1:0]                  in_value,
    input  logic [bsc_pkg::NUM_REQ_IN-1:0][bsc_pkg::REQ_W-1:0] in_req,
    input  bsc_pkg::cmd_t                                cmd,
    output bsc_pkg::sts_t                                sts
);
    import bsc_pkg::*;

    count_t max_reg  [NUM_PROCS][NUM_RES];
    count_t held_reg [NUM_PROCS][NUM_RES];
    count_t free_reg [NUM_RES];
    work_t  work_reg [NUM_RES];
    logic [NUM_PROCS-1:0] finished_reg;
    logic   trial_reg;

    count_t trow_reg [NUM_RES];
    pidx_t  tproc_reg;
    pidx_t  order_reg [NUM_PROCS];
    logic [PROCF_W-1:0] lproc_reg;
    req_t   lreq_reg [NUM_RES];

    req_t   req_in   [NUM_RES];
    logic   wr_ok;
    pidx_t  wr_pidx;
    ridx_t  wr_ridx;
    count_t wr_val;
    pidx_t  lpidx;
    pidx_t  addr;
    count_t max_row  [NUM_RES];
    count_t held_row [NUM_RES];
    count_t held_eff [NUM_RES];
    logic signed [NEED_W-1:0] need [NUM_RES];
    logic [NUM_RES-1:0] fits_r;
    logic [NUM_RES-1:0] exceeds_r;
    logic [NUM_RES-1:0] notfree_r;
    logic [CMP_W-1:0] trial_sum  [NUM_RES];
    logic [CMP_W-1:0] trial_diff [NUM_RES];

    for (genvar r = 0; r < NUM_RES; r++) begin : g_req
        if (r < NUM_REQ_IN) begin : g_used
            assign req_in[r] = in_req[r];
        end else begin : g_zero
            assign req_in[r] = '0;
        end
    end

    assign wr_ok   = (int'(in_proc) < NUM_PROCS) && (int'(in_res) < NUM_RES);
    assign wr_pidx = pidx_t'(in_proc);
    assign wr_ridx = ridx_t'(in_res);
    assign wr_val  = count_t'(in_value);
    assign lpidx   = pidx_t'(lproc_reg);
    assign addr    = cmd.use_scan ? cmd.p_idx : lpidx;

    always_comb begin
        for (int r = 0; r < NUM_RES; r++) begin
            max_row[r]  = max_reg[addr][r];
            held_row[r] = held_reg[addr][r];
            held_eff[r] = (trial_reg && (addr == tproc_reg)) ? trow_reg[r] : held_row[r];
            need[r]     = $signed({1'b0, max_row[r]}) - $signed({1'b0, held_eff[r]});
            fits_r[r]   = $signed({{(WORK_W + 1 - NEED_W){need[r][NEED_W-1]}}, need[r]})
                          <= $signed({1'b0, work_reg[r]});
            exceeds_r[r] = $signed({{(CMP_W - REQ_W){1'b0}}, lreq_reg[r]})
                           > $signed({{(CMP_W - NEED_W){need[r][NEED_W-1]}}, need[r]});
            notfree_r[r] = {{(CMP_W - REQ_W){1'b0}}, lreq_reg[r]}
                           > {{(CMP_W - COUNT_WIDTH){1'b0}}, free_reg[r]};
            trial_sum[r]  = {{(CMP_W - COUNT_WIDTH){1'b0}}, held_row[r]}
                            + {{(CMP_W - REQ_W){1'b0}}, lreq_reg[r]};
            trial_diff[r] = {{(CMP_W - COUNT_WIDTH){1'b0}}, free_reg[r]}
                            - {{(CMP_W - REQ_W){1'b0}}, lreq_reg[r]};
        end
    end

    assign sts.proc_ok     = int'(lproc_reg) < NUM_PROCS;
    assign sts.req_exceeds = |exceeds_r;
    assign sts.req_notfree = |notfree_r;
    assign sts.fits        = !finished_reg[cmd.p_idx] && (&fits_r);
    assign sts.seq         = order_reg[cmd.k_idx];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int p = 0; p < NUM_PROCS; p++) begin
                for (int r = 0; r < NUM_RES; r++) begin
                    max_reg[p][r]  <= '0;
                    held_reg[p][r] <= '0;
                end
            end
            for (int r = 0; r < NUM_RES; r++) begin
                free_reg[r] <= '0;
                work_reg[r] <= '0;
            end
            finished_reg <= '0;
            trial_reg    <= 1'b0;
        end else begin
            if (cmd.wr_max && wr_ok) begin
                max_reg[wr_pidx][wr_ridx] <= wr_val;
            end
            if (cmd.wr_held && wr_ok) begin
                held_reg[wr_pidx][wr_ridx] <= wr_val;
            end
            if (cmd.wr_free && wr_ok) begin
                free_reg[wr_ridx] <= wr_val;
            end
            if (cmd.load) begin
                trial_reg <= 1'b0;
            end
            if (cmd.safe_start) begin
                for (int r = 0; r < NUM_RES; r++) begin
                    work_reg[r] <= work_t'(free_reg[r]);
                end
                finished_reg <= '0;
                trial_reg    <= 1'b0;
            end
            if (cmd.trial_start) begin
                for (int r = 0; r < NUM_RES; r++) begin
                    work_reg[r] <= work_t'(trial_diff[r]);
                end
                finished_reg <= '0;
                trial_reg    <= 1'b1;
            end
            if (cmd.finish) begin
                for (int r = 0; r < NUM_RES; r++) begin
                    work_reg[r] <= work_reg[r] + work_t'(held_eff[r]);
                end
                finished_reg[cmd.p_idx] <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            lproc_reg <= in_proc;
            for (int r = 0; r < NUM_RES; r++) begin
                lreq_reg[r] <= req_in[r];
            end
        end
        if (cmd.trial_start) begin
            tproc_reg <= lpidx;
            for (int r = 0; r < NUM_RES; r++) begin
                trow_reg[r] <= count_t'(trial_sum[r]);
            end
        end
        if (cmd.finish) begin
            order_reg[cmd.done_idx] <= cmd.p_idx;
        end
    end

    `BSC_ASSERT_IMP(a_finish_only_unfinished, cmd.finish, cmd.use_scan && !finished_reg[cmd.p_idx], "process finished twice in one check")
    `BSC_ASSERT_NEXT(a_check_clears_flags, cmd.safe_start || cmd.trial_start, finished_reg == '0, "finished flags not cleared at check start")

endmodule

### sv/bsc_ctrl.sv
`include "bankers_safety_check_core_macros.svh"

module bsc_ctrl (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [bsc_pkg::FUNC_W-1:0]    in_func,
    input  logic                          m_tready,
    output logic                          m_tvalid,
    output logic [bsc_pkg::STATUS_W-1:0]  m_status,
    output logic [bsc_pkg::SEQ_W-1:0]     m_seq,
    output logic                          m_last,
    output bsc_pkg::cmd_t                 cmd,
    input  bsc_pkg::sts_t                 sts
);
    import bsc_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_REQ,
        ST_SCAN,
        ST_EMIT
    } state_t;

    state_t  state_reg, state_next;
    pidx_t   p_reg, p_next;
    pidx_t   done_reg, done_next;
    pidx_t   k_reg, k_next;
    logic    progress_reg, progress_next;
    status_t res_status_reg, res_status_next;
    logic    m_valid_reg, m_valid_next;
    status_t m_status_reg, m_status_next;
    logic [SEQ_W-1:0] m_seq_reg, m_seq_next;
    logic    m_last_reg, m_last_next;

    logic accept;
    logic out_free;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;

    always_comb begin
        state_next      = state_reg;
        p_next          = p_reg;
        done_next       = done_reg;
        k_next          = k_reg;
        progress_next   = progress_reg;
        res_status_next = res_status_reg;
        m_valid_next    = m_valid_reg && !m_tready;
        m_status_next   = m_status_reg;
        m_seq_next      = m_seq_reg;
        m_last_next     = m_last_reg;

        cmd          = '0;
        cmd.p_idx    = p_reg;
        cmd.done_idx = done_reg;
        cmd.k_idx    = k_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    p_next        = '0;
                    done_next     = '0;
                    k_next        = '0;
                    progress_next = 1'b0;
                    unique case (in_func)
                        FUNC_WR_MAX:  cmd.wr_max  = 1'b1;
                        FUNC_WR_HELD: cmd.wr_held = 1'b1;
                        FUNC_WR_FREE: cmd.wr_free = 1'b1;
                        FUNC_SAFETY: begin
                            cmd.safe_start = 1'b1;
                            state_next     = ST_SCAN;
                        end
                        FUNC_REQUEST: begin
                            cmd.load   = 1'b1;
                            state_next = ST_REQ;
                        end
                        default: ;
                    endcase
                end
            end
            ST_REQ: begin
                priority if (!sts.proc_ok || sts.req_exceeds) begin
                    res_status_next = STS_EXCEED;
                    state_next      = ST_EMIT;
                end else if (sts.req_notfree) begin
                    res_status_next = STS_NOTFREE;
                    state_next      = ST_EMIT;
                end else begin
                    cmd.trial_start = 1'b1;
                    state_next      = ST_SCAN;
                end
            end
            ST_SCAN: begin
                cmd.use_scan = 1'b1;
                if (sts.fits) begin
                    cmd.finish    = 1'b1;
                    done_next     = done_reg + pidx_t'(1);
                    progress_next = 1'b1;
                end
                priority if (sts.fits && (done_reg == LAST_P)) begin
                    res_status_next = STS_SAFE;
                    state_next      = ST_EMIT;
                end else if (p_reg == LAST_P) begin
                    if (!(progress_reg || sts.fits)) begin
                        res_status_next = STS_UNSAFE;
                        state_next      = ST_EMIT;
                    end else begin
                        p_next        = '0;
                        progress_next = 1'b0;
                    end
                end else begin
                    p_next = p_reg + pidx_t'(1);
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    if (res_status_reg != STS_SAFE) begin
                        m_status_next = res_status_reg;
                        m_seq_next    = '0;
                        m_last_next   = 1'b1;
                        state_next    = ST_IDLE;
                    end else begin
                        m_status_next = STS_SAFE;
                        m_seq_next    = SEQ_W'(sts.seq);
                        m_last_next   = (k_reg == LAST_P);
                        k_next        = k_reg + pidx_t'(1);
                        if (k_reg == LAST_P) begin
                            state_next = ST_IDLE;
                        end
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            p_reg          <= '0;
            done_reg       <= '0;
            k_reg          <= '0;
            progress_reg   <= 1'b0;
            res_status_reg <= STS_SAFE;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            p_reg          <= p_next;
            done_reg       <= done_next;
            k_reg          <= k_next;
            progress_reg   <= progress_next;
            res_status_reg <= res_status_next;
            m_valid_reg    <= m_valid_next;
        end
        m_status_reg <= m_status_next;
        m_seq_reg    <= m_seq_next;
        m_last_reg   <= m_last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_status = m_status_reg;
    assign m_seq    = m_seq_reg;
    assign m_last   = m_last_reg;

    `BSC_ASSERT_IMP(a_error_beat_single, m_valid_reg && (m_status_reg != STS_SAFE), (m_seq_reg == '0) && m_last_reg, "error result must be a single beat with zero sequence")
    `BSC_ASSERT_IMP(a_scan_entry_clear, (state_reg == ST_SCAN) && ($past(state_reg) != ST_SCAN), (p_reg == '0) && (done_reg == '0) && !progress_reg, "scan entered with stale counters")
    `BSC_ASSERT_IMP(a_unsafe_at_pass_end, (state_reg == ST_SCAN) && (state_next == ST_EMIT) && (res_status_next == STS_UNSAFE), p_reg == LAST_P, "unsafe reported before the end of a pass")

endmodule

### sv/bankers_safety_check_core.sv
// Banker's algorithm safety and request checker.
// The slave channel takes one command per beat: table writes (maximum claim, held
// units, free units), a safety check, or a request check for one process. The
// master channel returns results: a safe outcome gives NUM_PROCS beats carrying the
// safe sequence in order, any other outcome gives one beat; tlast marks the final
// beat of each command. Table writes give no result and leave the core idle.
// A safety check scans one process row per cycle through the need compare and the
// work-vector adder, making passes over the processes until all finish or a pass
// finishes none. A request check first tests the request against need and free
// units in its own state before its trial scan.
// A new command is accepted once the previous one has placed its last beat in the
// output register, so the next command starts while that beat still waits.
// When the receiver stalls, the held beat stays stable and the scan of the next
// command is not held up until its own first result is ready.
// Reset clears all three tables to zero, drops tvalid and returns to idle.
module bankers_safety_check_core (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // func[2:0], proc[5:3], res[7:6], value[15:8], req_0[23:16], req_1[31:24],
    // req_2[39:32], req_3[47:40]
    input  logic [bsc_pkg::IN_DATA_W-1:0]     s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // status[1:0], seq_proc[4:2], zero fill [7:5]
    output logic [bsc_pkg::OUT_DATA_W-1:0]    m_tdata,
    output logic                              m_tlast
);
    import bsc_pkg::*;

    logic [FUNC_W-1:0]   in_func;
    logic [PROCF_W-1:0]  in_proc;
    logic [RESF_W-1:0]   in_res;
    logic [VALUE_W-1:0]  in_value;
    logic [NUM_REQ_IN-1:0][REQ_W-1:0] in_req;
    logic [STATUS_W-1:0] m_status;
    logic [SEQ_W-1:0]    m_seq;
    cmd_t cmd;
    sts_t sts;

    assign in_func  = s_tdata[2:0];
    assign in_proc  = s_tdata[5:3];
    assign in_res   = s_tdata[7:6];
    assign in_value = s_tdata[15:8];

    for (genvar i = 0; i < NUM_REQ_IN; i++) begin : g_unpack
        assign in_req[i] = s_tdata[16 + REQ_W*i +: REQ_W];
    end

    assign m_tdata = {{(OUT_DATA_W - STATUS_W - SEQ_W){1'b0}}, m_seq, m_status};

    bsc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .in_func  (in_func),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_status (m_status),
        .m_seq    (m_seq),
        .m_last   (m_tlast),
        .cmd      (cmd),
        .sts      (sts)
    );

    bsc_datapath u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_proc  (in_proc),
        .in_res   (in_res),
        .in_value (in_value),
        .in_req   (in_req),
        .cmd      (cmd),
        .sts      (sts)
    );

endmodule

### tb/bankers_safety_check_core_tb.sv
module bankers_safety_check_core_tb;

    import bsc_pkg::*;

    localparam int IDLE_PCT     = 38;
    localparam int HOLD_CYCLES  = 300;
    localparam int STALL_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 100;
    localparam int MAX_PRINTS   = 100;

    typedef logic [NUM_REQ_IN-1:0][REQ_W-1:0] req_vec_t;

    typedef struct packed {
        req_vec_t            reqs;
        logic [VALUE_W-1:0]  value;
        logic [RESF_W-1:0]   res;
        logic [PROCF_W-1:0]  proc;
        logic [FUNC_W-1:0]   func;
    } command_t;

    typedef struct packed {
        status_t status;
        pidx_t   seq;
        logic    last;
    } beat_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tlast;

    count_t claim_tbl [NUM_PROCS][NUM_RES];
    count_t held_tbl [NUM_PROCS][NUM_RES];
    count_t free_vec [NUM_RES];
    int     trial_free [NUM_RES];
    int     trial_held [NUM_PROCS][NUM_RES];

    beat_t  pending_beats [$];
    beat_t  front_beat;
    int     mismatch_count = 0;
    int     beat_count = 0;
    int     items_sent = 0;
    int     stall_cycles = 0;
    int     hold_asks = 0;
    int     hold_seen = 0;
    int     hold_left = 0;
    bit     no_gaps = 1'b0;

    bankers_safety_check_core uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    initial begin
        for (int p = 0; p < NUM_PROCS; p++) begin
            for (int r = 0; r < NUM_RES; r++) begin
                claim_tbl[p][r] = '0;
                held_tbl[p][r] = '0;
            end
        end
        for (int r = 0; r < NUM_RES; r++) begin
            free_vec[r] = '0;
        end
    end

    // Runs the pass-by-pass safety scan on the trial tables and queues its beats.
    function automatic void queue_safety_outcome();
        int                   work [NUM_RES];
        pidx_t                order [NUM_PROCS];
        bit [NUM_PROCS-1:0]   finished;
        int                   n_done;
        bit                   progress;
        bit                   fits;
        beat_t                b;
        for (int r = 0; r < NUM_RES; r++) begin
            work[r] = trial_free[r];
        end
        finished = '0;
        n_done = 0;
        progress = 1'b1;
        while (n_done < NUM_PROCS && progress) begin
            progress = 1'b0;
            for (int p = 0; p < NUM_PROCS; p++) begin
                if (!finished[p]) begin
                    fits = 1'b1;
                    for (int r = 0; r < NUM_RES; r++) begin
                        if (int'(claim_tbl[p][r]) - trial_held[p][r] > work[r]) begin
                            fits = 1'b0;
                        end
                    end
                    if (fits) begin
                        for (int r = 0; r < NUM_RES; r++) begin
                            work[r] += trial_held[p][r];
                        end
                        order[n_done] = pidx_t'(p);
                        n_done++;
                        finished[p] = 1'b1;
                        progress = 1'b1;
                    end
                end
            end
        end
        if (n_done < NUM_PROCS) begin
            b = '{STS_UNSAFE, pidx_t'(0), 1'b1};
            pending_beats.push_back(b);
        end else begin
            for (int k = 0; k < NUM_PROCS; k++) begin
                b = '{STS_SAFE, order[k], k == NUM_PROCS - 1};
                pending_beats.push_back(b);
            end
        end
    endfunction

    function automatic void apply_command(input command_t c);
        status_t verdict;
        int      need;
        beat_t   b;
        verdict = STS_SAFE;
        case (c.func)
            FUNC_WR_MAX: claim_tbl[c.proc][c.res] = c.value;
            FUNC_WR_HELD: held_tbl[c.proc][c.res] = c.value;
            FUNC_WR_FREE: free_vec[c.res] = c.value;
            FUNC_SAFETY: begin
                for (int p = 0; p < NUM_PROCS; p++) begin
                    for (int r = 0; r < NUM_RES; r++) begin
                        trial_held[p][r] = int'(held_tbl[p][r]);
                    end
                end
                for (int r = 0; r < NUM_RES; r++) begin
                    trial_free[r] = int'(free_vec[r]);
                end
                queue_safety_outcome();
            end
            FUNC_REQUEST: begin
                for (int r = 0; r < NUM_RES; r++) begin
                    need = int'(claim_tbl[c.proc][r]) - int'(held_tbl[c.proc][r]);
                    if (int'(c.reqs[r]) > need) begin
                        verdict = STS_EXCEED;
                    end
                end
                if (verdict == STS_SAFE) begin
                    for (int r = 0; r < NUM_RES; r++) begin
                        if (int'(c.reqs[r]) > int'(free_vec[r])) begin
                            verdict = STS_NOTFREE;
                        end
                    end
                end
                if (verdict != STS_SAFE) begin
                    b = '{verdict, pidx_t'(0), 1'b1};
                    pending_beats.push_back(b);
                end else begin
                    for (int p = 0; p < NUM_PROCS; p++) begin
                        for (int r = 0; r < NUM_RES; r++) begin
                            trial_held[p][r] = int'(held_tbl[p][r]);
                        end
                    end
                    for (int r = 0; r < NUM_RES; r++) begin
                        trial_free[r] = int'(free_vec[r]) - int'(c.reqs[r]);
                        trial_held[c.proc][r] += int'(c.reqs[r]);
                    end
                    queue_safety_outcome();
                end
            end
            default: ;
        endcase
    endfunction

    function automatic command_t pack_command(input logic [FUNC_W-1:0] func,
                                              input int proc, input int res,
                                              input int value, input req_vec_t reqs);
        command_t c;
        c.func = func;
        c.proc = proc[PROCF_W-1:0];
        c.res = res[RESF_W-1:0];
        c.value = value[VALUE_W-1:0];
        c.reqs = reqs;
        return c;
    endfunction

    // Mostly requests that respect need and free units, so that trial scans are reached.
    function automatic req_vec_t pick_request(input int proc);
        req_vec_t rv;
        int       need;
        int       lim;
        for (int r = 0; r < NUM_RES; r++) begin
            need = int'(claim_tbl[proc][r]) - int'(held_tbl[proc][r]);
            lim = (need < int'(free_vec[r])) ? need : int'(free_vec[r]);
            if (lim < 0) begin
                lim = 0;
            end
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: rv[r] = REQ_W'($urandom_range(0, lim));
                6, 7: rv[r] = REQ_W'($urandom_range(0, 15));
                default: rv[r] = REQ_W'($urandom_range(0, 255));
            endcase
        end
        return rv;
    endfunction

    function automatic command_t random_command();
        command_t c;
        int       pick;
        c.proc = PROCF_W'($urandom_range(0, NUM_PROCS - 1));
        c.res = RESF_W'($urandom_range(0, NUM_RES - 1));
        if ($urandom_range(0, 9) < 7) begin
            c.value = VALUE_W'($urandom_range(0, 12));
        end else begin
            c.value = VALUE_W'($urandom_range(0, 255));
        end
        c.reqs = '0;
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
            c.func = FUNC_W'($urandom_range(FUNC_WR_MAX, FUNC_WR_FREE));
        end else if (pick < 75) begin
            c.func = FUNC_SAFETY;
        end else if (pick < 96) begin
            c.func = FUNC_REQUEST;
            c.reqs = pick_request(c.proc);
        end else begin
            c.func = FUNC_W'($urandom_range(FUNC_REQUEST + 1, {FUNC_W{1'b1}}));
        end
        return c;
    endfunction

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTS) begin
            $display("MISMATCH beat %0d: %s", beat_count, msg);
        end
    endtask

    task automatic send_command(input command_t c);
        @(negedge aclk);
        while (!no_gaps && $urandom_range(0, 99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= c;
        do begin
            @(posedge aclk);
        end while (!s_tready);
        apply_command(c);
        if (c.func <= FUNC_REQUEST) begin
            items_sent++;
        end
    endtask

    task automatic pause_for_drain();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_beats.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    task automatic test_directed();
        send_command(pack_command(FUNC_SAFETY, 0, 0, 0, '0));
        for (int k = 1; k <= 3; k++) begin
            send_command(pack_command(FUNC_W'(int'(FUNC_REQUEST) + k), 0, 0, 0, '0));
        end
        send_command(pack_command(FUNC_WR_MAX, 7, 3, 255, '0));
        send_command(pack_command(FUNC_SAFETY, 0, 0, 0, '0));
        send_command(pack_command(FUNC_WR_FREE, 0, 3, 255, '0));
        send_command(pack_command(FUNC_SAFETY, 0, 0, 0, '0));
        send_command(pack_command(FUNC_REQUEST, 7, 0, 0, {8'd255, 8'd0, 8'd0, 8'd0}));
        send_command(pack_command(FUNC_REQUEST, 7, 0, 0, {8'd255, 8'd0, 8'd0, 8'd1}));
        send_command(pack_command(FUNC_REQUEST, 7, 0, 0, {8'd255, 8'd255, 8'd255, 8'd255}));
        send_command(pack_command(FUNC_WR_FREE, 5, 3, 8, '0));
        send_command(pack_command(FUNC_REQUEST, 7, 0, 0, {8'd9, 8'd0, 8'd0, 8'd0}));
        // Held above the claim leaves a negative need.
        send_command(pack_command(FUNC_WR_HELD, 2, 1, 200, '0));
        send_command(pack_command(FUNC_SAFETY, 0, 0, 0, '0));
        send_command(pack_command(FUNC_REQUEST, 2, 0, 0, '0));
        send_command(pack_command(FUNC_REQUEST, 7, 0, 0, {8'd8, 8'd0, 8'd0, 8'd0}));
        // Process 0 can only finish on the second pass.
        send_command(pack_command(FUNC_WR_MAX, 7, 3, 0, '0));
        send_command(pack_command(FUNC_WR_MAX, 0, 0, 5, '0));
        send_command(pack_command(FUNC_WR_MAX, 1, 0, 5, '0));
        send_command(pack_command(FUNC_WR_HELD, 1, 0, 5, '0));
        send_command(pack_command(FUNC_SAFETY, 0, 0, 0, '0));
        send_command(pack_command(FUNC_REQUEST, 0, 0, 0, {8'd0, 8'd0, 8'd0, 8'd5}));
    endtask

    task automatic test_consistent_rows();
        int p;
        int m;
        repeat (24) begin
            p = $urandom_range(0, NUM_PROCS - 1);
            for (int r = 0; r < NUM_RES; r++) begin
                m = $urandom_range(0, 12);
                send_command(pack_command(FUNC_WR_MAX, p, r, m, '0));
                send_command(pack_command(FUNC_WR_HELD, p, r, $urandom_range(0, m), '0));
            end
            if ($urandom_range(0, 1) == 1) begin
                send_command(pack_command(FUNC_WR_FREE, $urandom_range(0, NUM_PROCS - 1),
                                          $urandom_range(0, NUM_RES - 1),
                                          $urandom_range(0, 10), '0));
            end
            send_command(pack_command(FUNC_SAFETY, 0, 0, 0, '0));
            send_command(pack_command(FUNC_REQUEST, p, 0, 0, pick_request(p)));
            m = $urandom_range(0, NUM_PROCS - 1);
            send_command(pack_command(FUNC_REQUEST, m, 0, 0, pick_request(m)));
        end
    endtask

    task automatic test_noise(input int count);
        int target;
        target = items_sent + count;
        while (items_sent < target) begin
            send_command(random_command());
        end
    endtask

    task automatic test_back_to_back();
        no_gaps = 1'b1;
        test_noise(40);
        no_gaps = 1'b0;
    endtask

    task automatic test_backpressure();
        int p;
        hold_asks++;
        repeat (16) begin
            send_command(pack_command(FUNC_SAFETY, 0, 0, 0, '0));
            p = $urandom_range(0, NUM_PROCS - 1);
            send_command(pack_command(FUNC_REQUEST, p, 0, 0, pick_request(p)));
        end
        pause_for_drain();
    endtask

    initial begin
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        test_directed();
        test_consistent_rows();
        test_noise(110);
        test_back_to_back();
        test_backpressure();
        pause_for_drain();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("bankers_safety_check_core verification clean");
        end else begin
            $display("bankers_safety_check_core verification failed");
        end
        $finish;
    end

    always @(negedge aclk) begin
        if (hold_asks != hold_seen) begin
            hold_seen <= hold_asks;
            hold_left <= HOLD_CYCLES;
            m_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready <= 1'b0;
        end else if (no_gaps) begin
            m_tready <= 1'b1;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            beat_count++;
            if (pending_beats.size() == 0) begin
                report_mismatch($sformatf("unexpected beat, tdata %0h tlast %0b",
                                          m_tdata, m_tlast));
            end else begin
                front_beat = pending_beats.pop_front();
                if (m_tdata[STATUS_W-1:0] !== front_beat.status) begin
                    report_mismatch($sformatf("status %0d, expected %0d",
                                              m_tdata[STATUS_W-1:0], front_beat.status));
                end
                if (m_tdata[STATUS_W +: SEQ_W] !== front_beat.seq) begin
                    report_mismatch($sformatf("seq_proc %0d, expected %0d",
                                              m_tdata[STATUS_W +: SEQ_W], front_beat.seq));
                end
                if (m_tlast !== front_beat.last) begin
                    report_mismatch($sformatf("tlast %0b, expected %0b",
                                              m_tlast, front_beat.last));
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("bankers_safety_check_core verification failed");
            $finish;
        end
    end

endmodule
